>>> rtl/core/cdwq_pkg.sv
package cdwq_pkg;

    localparam int unsigned SAMPLE_W = 16;   // scale_weight / sent_weight field width
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned S_DATA_W = 24;   // 1 + 1 + 16 = 18, padded to 3 bytes
    localparam int unsigned M_DATA_W = 24;   // 3 + 1 + 16 = 20, padded to 3 bytes

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_STEP      = 3'd1,
        EV_MOVED_FWD = 3'd2,
        EV_MOVED_BWD = 3'd3,
        EV_INVALID   = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        DIR_EMPTY = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_BWD   = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        EDGE_LFALL = 2'd0,
        EDGE_LRISE = 2'd1,
        EDGE_RFALL = 2'd2,
        EDGE_RRISE = 2'd3
    } edge_t;

    // live direction plus terminal outcome while walking the edges of one sample
    typedef struct packed {
        dir_t   dir;
        event_t term;
    } recog_t;

    function automatic edge_t fwd_expect(input logic [1:0] pos);
        edge_t e;
        unique case (pos)
            2'd1:    e = EDGE_RFALL;
            2'd2:    e = EDGE_LRISE;
            2'd3:    e = EDGE_RRISE;
            default: e = EDGE_LFALL;
        endcase
        return e;
    endfunction

    function automatic edge_t bwd_expect(input logic [1:0] pos);
        edge_t e;
        unique case (pos)
            2'd1:    e = EDGE_LFALL;
            2'd2:    e = EDGE_RRISE;
            2'd3:    e = EDGE_LRISE;
            default: e = EDGE_RFALL;
        endcase
        return e;
    endfunction

    function automatic recog_t take_edge(input recog_t cur, input edge_t e,
                                         input logic [1:0] pos);
        recog_t r;
        edge_t  exp_e;
        r = cur;
        exp_e = (cur.dir == DIR_FWD) ? fwd_expect(pos) : bwd_expect(pos);
        if (cur.term == EV_NONE) begin
            if (cur.dir == DIR_EMPTY) begin
                if (e == EDGE_LFALL) begin
                    r.dir = DIR_FWD;
                end else if (e == EDGE_RFALL) begin
                    r.dir = DIR_BWD;
                end else begin
                    r.term = EV_INVALID;
                end
            end else if (pos != 2'd0 && e == exp_e) begin
                if (pos == 2'd3) begin
                    r.term = (cur.dir == DIR_FWD) ? EV_MOVED_FWD : EV_MOVED_BWD;
                end
            end else begin
                r.term = EV_INVALID;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/cdwq_recog.sv
module cdwq_recog
    import cdwq_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   step_en,
    input  logic   left_level,
    input  logic   right_level,
    output event_t event_res
);

    logic       left_prev_reg;
    logic       right_prev_reg;
    dir_t       dir_reg;
    logic [1:0] pos_reg;

    logic   l_edge;
    logic   r_edge;
    recog_t walk;
    recog_t walk_l;

    assign l_edge = left_level != left_prev_reg;
    assign r_edge = right_level != right_prev_reg;

    // left edge first, both edges see the same position
    always_comb begin
        walk_l = '{dir: dir_reg, term: EV_NONE};
        if (l_edge) begin
            walk_l = take_edge(walk_l, left_level ? EDGE_LRISE : EDGE_LFALL, pos_reg);
        end
        walk = walk_l;
        if (r_edge) begin
            walk = take_edge(walk_l, right_level ? EDGE_RRISE : EDGE_RFALL, pos_reg);
        end
        if (!(l_edge || r_edge)) begin
            event_res = EV_NONE;
        end else if (walk.term == EV_NONE) begin
            event_res = EV_STEP;
        end else begin
            event_res = walk.term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_prev_reg  <= 1'b1;
            right_prev_reg <= 1'b1;
            dir_reg        <= DIR_EMPTY;
            pos_reg        <= 2'd0;
        end else if (step_en) begin
            left_prev_reg  <= left_level;
            right_prev_reg <= right_level;
            if (l_edge || r_edge) begin
                if (walk.term == EV_NONE) begin
                    dir_reg <= walk.dir;
                    pos_reg <= pos_reg + 2'd1;
                end else begin
                    dir_reg <= DIR_EMPTY;
                    pos_reg <= 2'd0;
                end
            end
        end
    end

endmodule

>>> rtl/core/cdwq_ring.sv
module cdwq_ring #(
    parameter int unsigned QUEUE_DEPTH = 3,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [WEIGHT_BITS-1:0] push_data,
    output logic                   evict_valid,
    output logic [WEIGHT_BITS-1:0] evict_data
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [WEIGHT_BITS-1:0] mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [IDX_W-1:0]       rd_addr;
    logic                   full_reg;
    logic [WEIGHT_BITS-1:0] rd_reg;

    assign idx_next    = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
    assign rd_addr     = push ? idx_next : idx_reg;
    assign evict_valid = push && full_reg;
    assign evict_data  = rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            full_reg <= 1'b0;
        end else if (push) begin
            idx_reg <= idx_next;
            if (idx_reg == LAST_IDX) begin
                full_reg <= 1'b1;
            end
        end
    end

    // rd_reg always holds the entry at the write pointer (write-first on a hit)
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[idx_reg] <= push_data;
        end
        if (push && rd_addr == idx_reg) begin
            rd_reg <= push_data;
        end else begin
            rd_reg <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/cargo_direction_weight_queue.sv
// Path: input register, then result register, from s_ transaction to m_tvalid.
// Throughput: one transaction per cycle unless m_tready holds the result register;
// one result per input, no stalls of its own; recogniser/ring step between registers.
// Reset: synchronous on aresetn low; sensor history idles high, recogniser empty,
// held weight zero, ring pointer and full flag cleared. Ring contents are not cleared.
module cargo_direction_weight_queue
    import cdwq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 3,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // [0] left_level, [1] right_level, [17:2] scale_weight, [23:18] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] event_res, [3] sent_valid, [19:4] sent_weight, [23:20] zero
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready
);

    // input stage
    logic                s1_valid_reg;
    logic                s1_left_reg;
    logic                s1_right_reg;
    logic [SAMPLE_W-1:0] s1_weight_reg;

    // result stage
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic                   advance;
    event_t                 event_res;
    logic [WEIGHT_BITS-1:0] held_weight_reg;
    logic [WEIGHT_BITS-1:0] sample_weight;
    logic                   push;
    logic                   sent_valid;
    logic [WEIGHT_BITS-1:0] evict_data;
    logic [SAMPLE_W-1:0]    sent_weight;
    logic [M_DATA_W-1:0]    m_data_next;

    // a transaction moves on when the result slot is empty or being drained
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_left_reg   <= s_tdata[0];
            s1_right_reg  <= s_tdata[1];
            s1_weight_reg <= s_tdata[SAMPLE_W+1:2];
        end
    end

    cdwq_recog u_recog (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .left_level  (s1_left_reg),
        .right_level (s1_right_reg),
        .event_res   (event_res)
    );

    // sign-extend or wrap the 16-bit sample into the held width
    assign sample_weight = WEIGHT_BITS'($signed(s1_weight_reg));

    // forward completion enqueues the previous load only if it is non-zero
    assign push = advance && (event_res == EV_MOVED_FWD) && (held_weight_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_weight_reg <= '0;
        end else if (advance) begin
            case (event_res)
                EV_MOVED_FWD: held_weight_reg <= sample_weight;
                EV_MOVED_BWD: held_weight_reg <= '0;
                default:      held_weight_reg <= held_weight_reg;
            endcase
        end
    end

    cdwq_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_data   (held_weight_reg),
        .evict_valid (sent_valid),
        .evict_data  (evict_data)
    );

    // evicted weight back to 16 bits, zero when nothing leaves the ring
    assign sent_weight = sent_valid ? SAMPLE_W'($signed(evict_data)) : '0;
    assign m_data_next = M_DATA_W'({sent_weight, sent_valid, event_res});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> rtl/core/cdwq_checker.sv
module cdwq_checker
    import cdwq_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tvalid,
    input logic                m_tready
);

    logic [EVENT_W-1:0] ev;
    assign ev = m_tdata[EVENT_W-1:0];

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a waiting input transaction keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input changed while stalled");

    // only a forward move can push a weight out of the ring; no weight without the flag
    a_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] ? ev == EV_MOVED_FWD : m_tdata[19:4] == '0))
        else $error("weight sent without forward move or flag");

    // event code and padding stay in range
    a_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ev == EV_NONE || ev == EV_STEP || ev == EV_MOVED_FWD ||
                      ev == EV_MOVED_BWD || ev == EV_INVALID) && m_tdata[23:20] == '0)
        else $error("bad event code or padding");

    // nothing is offered straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind cargo_direction_weight_queue cdwq_checker u_cdwq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

>>> tb/tb_cargo_direction_weight_queue.sv
`timescale 1ns / 100ps

module tb_cargo_direction_weight_queue;
    import cdwq_pkg::*;

    // Ring length as built into the block (default parameters)
    localparam int unsigned RING_DEPTH   = 3;
    localparam int unsigned CLK_HALF     = 4;     // 8 ns period
    localparam int unsigned RESET_CYCLES = 12;
    // Cycles with no transaction on either side before the run is declared hung.
    // The long hold-off below (LONG_HOLD) and the random stalls are far shorter.
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned LONG_HOLD    = 400;
    // Two register stages in the block; a little margin on top
    localparam int unsigned DRAIN_CYCLES = 10;

    // One expected result: the fields carried on m_tdata (less the zero padding)
    typedef struct packed {
        event_t                ev;
        logic                  sent_v;
        logic [SAMPLE_W-1:0]   sent_w;
    } cargo_result_t;

    // Running direction and outcome while the edges of one sample are walked
    typedef struct packed {
        dir_t   dir;
        event_t term;
    } edge_walk_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    cargo_direction_weight_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // ---------------------------------------------------------------------
    // Predictor state: own copy of the sensor history, recogniser and ring
    // ---------------------------------------------------------------------
    logic                left_seen;
    logic                right_seen;
    dir_t                dir_now;
    logic [1:0]          seq_pos;
    logic [SAMPLE_W-1:0] held_wt;
    logic [SAMPLE_W-1:0] wt_ring [RING_DEPTH];
    int unsigned         ring_wr;
    bit                  ring_wrapped;

    cargo_result_t       expected_moves [$];   // predictions awaiting their m_ transaction
    logic [S_DATA_W-1:0] sample_backlog [$];   // samples not yet offered on s_

    int unsigned mismatches  = 0;
    int unsigned results_in  = 0;
    int unsigned idle_cycles = 0;
    bit          s_took      = 1'b0;           // s_ transaction at the last rising edge

    // Idling knobs for the current phase, percent of cycles
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    bit          hold_arm = 1'b0;             // request one long receiver hold-off
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;

    // Generator's view of the sensor levels it last queued
    bit          gen_left  = 1'b1;
    bit          gen_right = 1'b1;
    bit          allow_repeats = 1'b0;
    int unsigned items_queued = 0;

    // ---------------------------------------------------------------------
    // Recogniser: one edge against the expected sequence
    // ---------------------------------------------------------------------
    function automatic edge_walk_t walk_edge(edge_walk_t w, edge_t e, logic [1:0] pos);
        edge_walk_t nw;
        edge_t      want;
        nw = w;
        // once a sample has completed or broken the pattern, later edges are ignored
        if (w.term != EV_NONE)
            return nw;
        if (w.dir == DIR_EMPTY) begin
            if (e == EDGE_LFALL)
                nw.dir = DIR_FWD;
            else if (e == EDGE_RFALL)
                nw.dir = DIR_BWD;
            else
                nw.term = EV_INVALID;
        end else begin
            // forward: L fall, R fall, L rise, R rise; backward mirrors it
            case (pos)
                2'd1:    want = (w.dir == DIR_FWD) ? EDGE_RFALL : EDGE_LFALL;
                2'd2:    want = (w.dir == DIR_FWD) ? EDGE_LRISE : EDGE_RRISE;
                default: want = (w.dir == DIR_FWD) ? EDGE_RRISE : EDGE_LRISE;
            endcase
            // position 0 in a moving state means both edges of one sample opened the pattern
            if (pos == 2'd0 || e != want)
                nw.term = EV_INVALID;
            else if (pos == 2'd3)
                nw.term = (w.dir == DIR_FWD) ? EV_MOVED_FWD : EV_MOVED_BWD;
        end
        return nw;
    endfunction

    // Whole-sample update; both edges of one sample share the same position
    function automatic cargo_result_t predict_cargo(logic [S_DATA_W-1:0] d);
        cargo_result_t       res;
        edge_walk_t          w;
        bit                  any_edge;
        logic                lv;
        logic                rv;
        logic [SAMPLE_W-1:0] wt;
        lv = d[0];
        rv = d[1];
        wt = d[SAMPLE_W+1:2];
        res = '{ev: EV_NONE, sent_v: 1'b0, sent_w: '0};
        w = '{dir: dir_now, term: EV_NONE};
        any_edge = 1'b0;
        // left edge first, then right
        if (lv != left_seen) begin
            any_edge = 1'b1;
            left_seen = lv;
            w = walk_edge(w, lv ? EDGE_LRISE : EDGE_LFALL, seq_pos);
        end
        if (rv != right_seen) begin
            any_edge = 1'b1;
            right_seen = rv;
            w = walk_edge(w, rv ? EDGE_RRISE : EDGE_RFALL, seq_pos);
        end
        if (any_edge) begin
            case (w.term)
                EV_NONE: begin
                    dir_now = w.dir;
                    seq_pos = seq_pos + 2'd1;
                    res.ev = EV_STEP;
                end
                EV_MOVED_FWD: begin
                    // a zero held weight is never queued
                    if (held_wt != '0) begin
                        if (ring_wrapped) begin
                            res.sent_v = 1'b1;
                            res.sent_w = wt_ring[ring_wr];
                        end
                        wt_ring[ring_wr] = held_wt;
                        if (ring_wr + 1 >= RING_DEPTH) begin
                            ring_wr = 0;
                            ring_wrapped = 1'b1;
                        end else begin
                            ring_wr = ring_wr + 1;
                        end
                    end
                    held_wt = wt;
                    dir_now = DIR_EMPTY;
                    seq_pos = 2'd0;
                    res.ev = EV_MOVED_FWD;
                end
                EV_MOVED_BWD: begin
                    held_wt = '0;
                    dir_now = DIR_EMPTY;
                    seq_pos = 2'd0;
                    res.ev = EV_MOVED_BWD;
                end
                default: begin
                    dir_now = DIR_EMPTY;
                    seq_pos = 2'd0;
                    res.ev = EV_INVALID;
                end
            endcase
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on result %0d, %s: got %0h, expected %0h",
                 $realtime, results_in, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Monitor: predicts on every s_ transaction, checks every m_ transaction,
    // and keeps the hang watchdog. Everything sampled at the rising edge.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        cargo_result_t want;
        bit            m_took;
        s_took = aresetn && s_tvalid && s_tready;
        m_took = aresetn && m_tvalid && m_tready;
        if (s_took)
            expected_moves.push_back(predict_cargo(s_tdata));
        if (m_took) begin
            if (expected_moves.size() == 0) begin
                flag_mismatch("result with nothing expected", 32'(m_tdata), 0);
            end else begin
                want = expected_moves.pop_front();
                if (m_tdata[EVENT_W-1:0] != want.ev)
                    flag_mismatch("event_res", 32'(m_tdata[EVENT_W-1:0]), 32'(want.ev));
                if (m_tdata[EVENT_W] != want.sent_v)
                    flag_mismatch("sent_valid", 32'(m_tdata[EVENT_W]), 32'(want.sent_v));
                if (m_tdata[EVENT_W+SAMPLE_W:EVENT_W+1] != want.sent_w)
                    flag_mismatch("sent_weight", 32'(m_tdata[EVENT_W+SAMPLE_W:EVENT_W+1]),
                                  32'(want.sent_w));
                if (m_tdata[M_DATA_W-1:EVENT_W+SAMPLE_W+1] != '0)
                    flag_mismatch("padding",
                                  32'(m_tdata[M_DATA_W-1:EVENT_W+SAMPLE_W+1]), 0);
            end
            results_in++;
        end
        if (aresetn) begin
            if (s_took || m_took)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender: offers queued samples from the falling edge, holding each
    // until its transaction completes. Gaps only between transactions.
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                s_tdata  <= sample_backlog.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off counted here so that
    // the block backs up and drops s_tready
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------------
    function automatic logic [SAMPLE_W-1:0] rand_weight();
        int unsigned pick;
        pick = $urandom_range(19);
        case (pick)
            0, 1:    return '0;                    // zero weight, nothing to queue later
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'hFFFF;
            5:       return 16'h0001;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic add_sample(bit lv, bit rv, logic [SAMPLE_W-1:0] wt);
        sample_backlog.push_back({{(S_DATA_W-SAMPLE_W-2){1'b0}}, wt, rv, lv});
        gen_left  = lv;
        gen_right = rv;
        items_queued++;
    endtask

    // First len samples of a forward or backward pass; last_wt rides on the fourth
    task automatic add_pattern(bit fwd, int unsigned len, logic [SAMPLE_W-1:0] last_wt);
        bit [1:0] lvl;
        for (int unsigned k = 0; k < len; k++) begin
            if (k == 0 && !(gen_left && gen_right))
                add_sample(1'b1, 1'b1, rand_weight());   // back to idle first
            case (k)
                0:       lvl = fwd ? 2'b01 : 2'b10;      // {left, right}
                1:       lvl = 2'b00;
                2:       lvl = fwd ? 2'b10 : 2'b01;
                default: lvl = 2'b11;
            endcase
            add_sample(lvl[1], lvl[0], (k == 3) ? last_wt : rand_weight());
            // an occasional unchanged sample in the middle of a pass
            if (allow_repeats && k < 3 && $urandom_range(9) == 0)
                add_sample(lvl[1], lvl[0], rand_weight());
        end
    endtask

    task automatic add_random_items(int unsigned n_items);
        int unsigned target;
        int unsigned kind;
        target = items_queued + n_items;
        while (items_queued < target) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                add_pattern(1'b1, 4, rand_weight());
            end else if (kind < 75) begin
                add_pattern(1'b0, 4, rand_weight());
            end else if (kind < 87) begin
                // broken pass: a prefix, then whatever the sensors do next
                add_pattern(1'($urandom_range(1)), $urandom_range(1, 3), '0);
                add_sample(1'($urandom_range(1)), 1'($urandom_range(1)), rand_weight());
            end else if (kind < 95) begin
                repeat ($urandom_range(1, 4))
                    add_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                               rand_weight());
            end else begin
                add_sample(gen_left, gen_right, rand_weight());
            end
        end
    endtask

    task automatic wait_drained();
        while (sample_backlog.size() != 0 || s_tvalid || expected_moves.size() != 0)
            @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    initial begin
        left_seen    = 1'b1;
        right_seen   = 1'b1;
        dir_now      = DIR_EMPTY;
        seq_pos      = 2'd0;
        held_wt      = '0;
        ring_wr      = 0;
        ring_wrapped = 1'b0;
        for (int unsigned i = 0; i < RING_DEPTH; i++)
            wt_ring[i] = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: no edge, forward with nothing held, forward queuing 7FFF,
        // backward clearing the held 8000, forward with a zero held weight
        add_sample(1'b1, 1'b1, 16'h0000);
        add_pattern(1'b1, 4, 16'h7FFF);
        add_pattern(1'b1, 4, 16'h8000);
        add_pattern(1'b0, 4, 16'h1234);
        add_pattern(1'b1, 4, 16'hFFFF);
        // both sensors fall together: the right fall finds position 0 while moving
        add_sample(1'b0, 1'b0, 16'h5A5A);
        // both rise from empty: first edge breaks it, second is ignored
        add_sample(1'b1, 1'b1, 16'hA5A5);
        // left blinks: rise where right fall was expected
        add_sample(1'b0, 1'b1, 16'h0F0F);
        add_sample(1'b1, 1'b1, 16'hF0F0);
        // backward completes on the left rise; right fall in the same sample ignored
        add_pattern(1'b0, 3, '0);
        add_sample(1'b1, 1'b0, 16'h0002);
        add_sample(1'b1, 1'b1, 16'h7FFE);

        allow_repeats = 1'b1;

        // Phase 1: no idling on either side
        add_random_items(300);
        wait_drained();

        // Phase 2: sender mostly idle
        snd_idle_pct = 86;
        add_random_items(250);
        wait_drained();

        // Phase 3: receiver mostly stalling
        snd_idle_pct  = 0;
        rcv_stall_pct = 86;
        add_random_items(250);
        wait_drained();

        // Phase 4: both sides idle now and then
        snd_idle_pct  = 28;
        rcv_stall_pct = 28;
        add_random_items(350);
        wait_drained();

        // Phase 5: sender flat out while the receiver holds off for a long stretch
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        add_random_items(300);
        hold_arm = 1'b1;
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_moves.size() != 0)
            flag_mismatch("expectations left over", expected_moves.size(), 0);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/cdwq_pkg.sv
rtl/core/cdwq_recog.sv
rtl/core/cdwq_ring.sv
rtl/core/cargo_direction_weight_queue.sv
rtl/core/cdwq_checker.sv
tb/tb_cargo_direction_weight_queue.sv
